FILE: src/cmr_pkg.sv
package cmr_pkg;

    localparam int MAX_POINTS = 4;
    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    localparam int COORD_W    = 24;
    localparam int THR_W      = 40;
    localparam int OUTCOME_W  = 3;
    localparam int SLOT_W     = 2;
    localparam int PCOUNT_W   = 3;

    localparam logic [THR_W-1:0] THR_RESET = 40'd335544;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 64;
    localparam int REG_LSB    = 3;

    // register index taken from paddr[REG_LSB]
    localparam logic REG_NEAR_THRESHOLD = 1'b0;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_FRESH   = 3'd0,
        OUT_APPEND  = 3'd1,
        OUT_REPLACE = 3'd2,
        OUT_CLOSE   = 3'd3,
        OUT_INSIDE  = 3'd4
    } t_outcome;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DIFF_C,
        ST_SQ_C,
        ST_ACC_C,
        ST_CEN,
        ST_DIFF_1,
        ST_SQ_1,
        ST_ACC_1,
        ST_SQ_2,
        ST_ACC_2,
        ST_INSIDE,
        ST_WRITE
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CAPTURE,
        DP_LOAD,
        DP_DIFF_C,
        DP_SQ_MAG,
        DP_SQ,
        DP_ACC_C,
        DP_CEN,
        DP_DIFF_1,
        DP_ACC_1,
        DP_ACC,
        DP_WRITE
    } t_dp_op;

    typedef struct packed {
        t_dp_op           op;
        logic [IDX_W-1:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic too_close;
        logic in_centroid;
    } t_dp_sts;

endpackage

FILE: src/cmr_dp.sv
module cmr_dp (
    input  logic                                 i_clk,
    input  logic signed [cmr_pkg::COORD_W-1:0]   i_point_x,
    input  logic signed [cmr_pkg::COORD_W-1:0]   i_point_y,
    input  logic signed [cmr_pkg::COORD_W-1:0]   i_point_z,
    input  logic        [cmr_pkg::THR_W-1:0]     i_near_threshold,
    input  cmr_pkg::t_dp_cmd                     i_cmd,
    output cmr_pkg::t_dp_sts                     o_sts
);

    localparam int COORD_W = cmr_pkg::COORD_W;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SQ_W    = 2 * DIFF_W - 1;
    localparam int DIST_W  = SQ_W + 2;
    localparam int SUM_W   = COORD_W + cmr_pkg::IDX_W;
    localparam int RCP_SH  = SUM_W + cmr_pkg::IDX_W;
    localparam int RCP_W   = RCP_SH + 1;
    localparam int PROD_W  = SUM_W + RCP_W;
    localparam int NPTS    = cmr_pkg::MAX_POINTS;

    logic [3*COORD_W-1:0]      r_store [NPTS];

    logic signed [COORD_W-1:0] r_cand [3];
    logic signed [COORD_W-1:0] r_pt   [3];
    logic signed [SUM_W-1:0]   r_sum  [3];
    logic        [SUM_W-1:0]   r_mag  [3];
    logic                      r_neg  [3];
    logic        [PROD_W-1:0]  r_prod [3];
    logic signed [COORD_W-1:0] r_cen  [3];
    logic signed [DIFF_W-1:0]  r_diff [3];
    logic        [SQ_W-1:0]    r_sq   [3];
    logic        [DIST_W-1:0]  r_dist;
    logic        [DIST_W-1:0]  r_d1;

    logic        [RCP_W-1:0]    w_rcp   [NPTS];
    logic signed [2*DIFF_W-1:0] w_sqp   [3];
    logic        [SUM_W-1:0]    w_mag   [3];
    logic signed [COORD_W-1:0]  w_quo   [3];
    logic        [DIST_W-1:0]   w_sq_sum;

    // reciprocal of (slot + 1), exact floor division for any running sum
    for (genvar g = 0; g < NPTS; g++) begin : g_rcp
        localparam logic [63:0] DIV = 64'(g + 1);
        localparam logic [63:0] RCP = ((64'd1 << RCP_SH) + DIV - 64'd1) / DIV;
        assign w_rcp[g] = RCP[RCP_W-1:0];
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sqp[k] = r_diff[k] * r_diff[k];
            w_mag[k] = r_sum[k][SUM_W-1] ? SUM_W'(-r_sum[k]) : SUM_W'(r_sum[k]);
            w_quo[k] = $signed(r_prod[k][RCP_SH +: COORD_W]);
        end
        w_sq_sum = DIST_W'(r_sq[0]) + DIST_W'(r_sq[1]) + DIST_W'(r_sq[2]);
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            cmr_pkg::DP_CAPTURE: begin
                r_cand[0] <= i_point_x;
                r_cand[1] <= i_point_y;
                r_cand[2] <= i_point_z;
                for (int k = 0; k < 3; k++) begin
                    r_sum[k] <= '0;
                end
            end
            cmr_pkg::DP_LOAD: begin
                for (int k = 0; k < 3; k++) begin
                    r_pt[k] <= $signed(r_store[i_cmd.idx][k*COORD_W +: COORD_W]);
                end
            end
            cmr_pkg::DP_DIFF_C: begin
                for (int k = 0; k < 3; k++) begin
                    r_diff[k] <= DIFF_W'(r_cand[k]) - DIFF_W'(r_pt[k]);
                    r_sum[k]  <= r_sum[k] + SUM_W'(r_pt[k]);
                end
            end
            cmr_pkg::DP_SQ_MAG: begin
                for (int k = 0; k < 3; k++) begin
                    r_sq[k]  <= w_sqp[k][SQ_W-1:0];
                    r_mag[k] <= w_mag[k];
                    r_neg[k] <= r_sum[k][SUM_W-1];
                end
            end
            cmr_pkg::DP_SQ: begin
                for (int k = 0; k < 3; k++) begin
                    r_sq[k] <= w_sqp[k][SQ_W-1:0];
                end
            end
            cmr_pkg::DP_ACC_C: begin
                r_dist <= w_sq_sum;
                for (int k = 0; k < 3; k++) begin
                    r_prod[k] <= r_mag[k] * w_rcp[i_cmd.idx];
                end
            end
            cmr_pkg::DP_CEN: begin
                // put the sign back after the magnitude division
                for (int k = 0; k < 3; k++) begin
                    r_cen[k] <= r_neg[k] ? -w_quo[k] : w_quo[k];
                end
            end
            cmr_pkg::DP_DIFF_1: begin
                for (int k = 0; k < 3; k++) begin
                    r_diff[k] <= DIFF_W'(r_cen[k]) - DIFF_W'(r_pt[k]);
                end
            end
            cmr_pkg::DP_ACC_1: begin
                r_d1 <= w_sq_sum;
                for (int k = 0; k < 3; k++) begin
                    r_diff[k] <= DIFF_W'(r_cen[k]) - DIFF_W'(r_cand[k]);
                end
            end
            cmr_pkg::DP_ACC: begin
                r_dist <= w_sq_sum;
            end
            cmr_pkg::DP_WRITE: begin
                r_store[i_cmd.idx] <= {r_cand[2], r_cand[1], r_cand[0]};
            end
            default: begin
            end
        endcase
    end

    assign o_sts.too_close   = r_dist < DIST_W'(i_near_threshold);
    assign o_sts.in_centroid = r_dist < r_d1;

endmodule

FILE: src/cmr_ctrl.sv
module cmr_ctrl (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_fresh,
    output logic                             o_busy,
    output cmr_pkg::t_dp_cmd                 o_cmd,
    input  cmr_pkg::t_dp_sts                 i_sts,
    output logic                             o_valid,
    output cmr_pkg::t_outcome                o_outcome,
    output logic [cmr_pkg::IDX_W-1:0]        o_slot,
    output logic [cmr_pkg::CNT_W-1:0]        o_count
);

    localparam int IDX_W = cmr_pkg::IDX_W;
    localparam int CNT_W = cmr_pkg::CNT_W;

    cmr_pkg::t_state   r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_fresh, n_fresh;
    logic              r_valid, n_valid;
    cmr_pkg::t_outcome r_outcome, n_outcome;
    logic [IDX_W-1:0]  r_slot, n_slot;
    logic [CNT_W-1:0]  r_pcount, n_pcount;

    logic              w_last;

    assign w_last = (CNT_W'(r_idx) + CNT_W'(1)) == r_count;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cmr_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_state = (i_fresh || r_count == '0) ? cmr_pkg::ST_WRITE
                                                         : cmr_pkg::ST_LOAD;
                end
            end
            cmr_pkg::ST_LOAD:   n_state = cmr_pkg::ST_DIFF_C;
            cmr_pkg::ST_DIFF_C: n_state = cmr_pkg::ST_SQ_C;
            cmr_pkg::ST_SQ_C:   n_state = cmr_pkg::ST_ACC_C;
            cmr_pkg::ST_ACC_C:  n_state = cmr_pkg::ST_CEN;
            cmr_pkg::ST_CEN: begin
                n_state = i_sts.too_close ? cmr_pkg::ST_IDLE : cmr_pkg::ST_DIFF_1;
            end
            cmr_pkg::ST_DIFF_1: n_state = cmr_pkg::ST_SQ_1;
            cmr_pkg::ST_SQ_1:   n_state = cmr_pkg::ST_ACC_1;
            cmr_pkg::ST_ACC_1:  n_state = cmr_pkg::ST_SQ_2;
            cmr_pkg::ST_SQ_2:   n_state = cmr_pkg::ST_ACC_2;
            cmr_pkg::ST_ACC_2:  n_state = cmr_pkg::ST_INSIDE;
            cmr_pkg::ST_INSIDE: begin
                if (i_sts.in_centroid) begin
                    n_state = cmr_pkg::ST_IDLE;
                end else if (w_last) begin
                    n_state = cmr_pkg::ST_WRITE;
                end else begin
                    n_state = cmr_pkg::ST_LOAD;
                end
            end
            cmr_pkg::ST_WRITE:  n_state = cmr_pkg::ST_IDLE;
            default:            n_state = cmr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd.op  = cmr_pkg::DP_NOP;
        o_cmd.idx = r_idx;
        n_idx     = r_idx;
        n_count   = r_count;
        n_fresh   = r_fresh;
        n_valid   = 1'b0;
        n_outcome = r_outcome;
        n_slot    = r_slot;
        n_pcount  = r_pcount;
        unique case (r_state)
            cmr_pkg::ST_IDLE: begin
                if (i_start) begin
                    o_cmd.op = cmr_pkg::DP_CAPTURE;
                    n_idx    = '0;
                    n_fresh  = i_fresh;
                end
            end
            cmr_pkg::ST_LOAD:   o_cmd.op = cmr_pkg::DP_LOAD;
            cmr_pkg::ST_DIFF_C: o_cmd.op = cmr_pkg::DP_DIFF_C;
            cmr_pkg::ST_SQ_C:   o_cmd.op = cmr_pkg::DP_SQ_MAG;
            cmr_pkg::ST_ACC_C:  o_cmd.op = cmr_pkg::DP_ACC_C;
            cmr_pkg::ST_CEN: begin
                o_cmd.op = cmr_pkg::DP_CEN;
                if (i_sts.too_close) begin
                    n_valid   = 1'b1;
                    n_outcome = cmr_pkg::OUT_CLOSE;
                    n_slot    = '0;
                    n_pcount  = r_count;
                end
            end
            cmr_pkg::ST_DIFF_1: o_cmd.op = cmr_pkg::DP_DIFF_1;
            cmr_pkg::ST_SQ_1:   o_cmd.op = cmr_pkg::DP_SQ;
            cmr_pkg::ST_ACC_1:  o_cmd.op = cmr_pkg::DP_ACC_1;
            cmr_pkg::ST_SQ_2:   o_cmd.op = cmr_pkg::DP_SQ;
            cmr_pkg::ST_ACC_2:  o_cmd.op = cmr_pkg::DP_ACC;
            cmr_pkg::ST_INSIDE: begin
                if (i_sts.in_centroid) begin
                    n_valid   = 1'b1;
                    n_outcome = cmr_pkg::OUT_INSIDE;
                    n_slot    = '0;
                    n_pcount  = r_count;
                end else if (!w_last) begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            cmr_pkg::ST_WRITE: begin
                o_cmd.op = cmr_pkg::DP_WRITE;
                n_valid  = 1'b1;
                if (r_fresh) begin
                    o_cmd.idx = '0;
                    n_count   = CNT_W'(1);
                    n_outcome = cmr_pkg::OUT_FRESH;
                end else if (r_count >= CNT_W'(cmr_pkg::MAX_POINTS)) begin
                    // the first slot is always nearest its own centroid
                    o_cmd.idx = '0;
                    n_outcome = cmr_pkg::OUT_REPLACE;
                end else begin
                    o_cmd.idx = r_count[IDX_W-1:0];
                    n_count   = r_count + CNT_W'(1);
                    n_outcome = cmr_pkg::OUT_APPEND;
                end
                n_slot   = o_cmd.idx;
                n_pcount = n_count;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmr_pkg::ST_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_fresh   <= n_fresh;
        r_outcome <= n_outcome;
        r_slot    <= n_slot;
        r_pcount  <= n_pcount;
    end

    assign o_busy    = r_state != cmr_pkg::ST_IDLE;
    assign o_valid   = r_valid;
    assign o_outcome = r_outcome;
    assign o_slot    = r_slot;
    assign o_count   = r_pcount;

endmodule

FILE: src/contact_manifold_reduction_unit.sv
// Channel   Handshake                      Payload
// -------   ----------------------------   -------------------------------------------
// config    psel/penable/pwrite, pready=1  paddr, pwdata, prdata (near_threshold at 0)
// request   start & !busy                  i_point_x/y/z, i_fresh_manifold
// result    o_valid, one cycle             o_outcome, o_slot, o_point_count
//
// A fresh request, or one arriving with an empty store, goes from accept
// straight to the write state, which raises the result strobe. Otherwise
// each stored point is walked through the shared lane datapath (squares,
// centroid reciprocal multiply, two distance passes) before the write;
// rejection ends the walk early. Synchronous reset empties the store and
// restores the threshold; the receiver cannot stall, so results never wait.
module contact_manifold_reduction_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cmr_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [cmr_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [cmr_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                 pready,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [cmr_pkg::COORD_W-1:0]   i_point_x,
    input  logic signed [cmr_pkg::COORD_W-1:0]   i_point_y,
    input  logic signed [cmr_pkg::COORD_W-1:0]   i_point_z,
    input  logic                                 i_fresh_manifold,
    output logic                                 o_valid,
    output logic [cmr_pkg::OUTCOME_W-1:0]        o_outcome,
    output logic [cmr_pkg::SLOT_W-1:0]           o_slot,
    output logic [cmr_pkg::PCOUNT_W-1:0]         o_point_count
);

    logic [cmr_pkg::THR_W-1:0] r_near_threshold;
    logic                      w_reg_sel;
    logic                      w_start;
    cmr_pkg::t_dp_cmd          w_cmd;
    cmr_pkg::t_dp_sts          w_sts;
    cmr_pkg::t_outcome         w_outcome;
    logic [cmr_pkg::IDX_W-1:0] w_slot;
    logic [cmr_pkg::CNT_W-1:0] w_count;

    assign w_reg_sel = paddr[cmr_pkg::REG_LSB] == cmr_pkg::REG_NEAR_THRESHOLD;
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near_threshold <= cmr_pkg::THR_RESET;
        end else if (psel && penable && pwrite && w_reg_sel) begin
            r_near_threshold <= pwdata[cmr_pkg::THR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (psel && !pwrite && w_reg_sel) begin
            prdata = cmr_pkg::APB_DATA_W'(r_near_threshold);
        end
    end

    assign w_start = start && !busy;

    cmr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_fresh   (i_fresh_manifold),
        .o_busy    (busy),
        .o_cmd     (w_cmd),
        .i_sts     (w_sts),
        .o_valid   (o_valid),
        .o_outcome (w_outcome),
        .o_slot    (w_slot),
        .o_count   (w_count)
    );

    cmr_dp u_dp (
        .i_clk            (i_clk),
        .i_point_x        (i_point_x),
        .i_point_y        (i_point_y),
        .i_point_z        (i_point_z),
        .i_near_threshold (r_near_threshold),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts)
    );

    assign o_outcome     = w_outcome;
    assign o_slot        = (cmr_pkg::SLOT_W)'(w_slot);
    assign o_point_count = (cmr_pkg::PCOUNT_W)'(w_count);

endmodule
